// File: rtl/core/utf8cp_pkg.sv
`timescale 1ns / 1ps

package utf8cp_pkg;

	localparam int POINT_W = 21;
	localparam int PEND_W  = 2;

	localparam logic [PEND_W-1:0] PEND_NONE  = 2'd0;
	localparam logic [PEND_W-1:0] PEND_ONE   = 2'd1;
	localparam logic [PEND_W-1:0] PEND_TWO   = 2'd2;
	localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

	typedef struct packed {
		logic [POINT_W-1:0] partial;
		logic [PEND_W-1:0]  pending;
	} dec_state_t;

	typedef struct packed {
		logic               emit;
		logic [POINT_W-1:0] code_point;
		logic               point_valid;
		logic               text_done;
	} dec_result_t;

endpackage

// File: rtl/core/utf8_to_codepoint_decoder.sv
`timescale 1ns / 1ps

// channel | dir | tdata                     | tuser           | tlast
// s_*     | in  | [7:0] data_byte           | -               | end_of_text
// m_*     | out | [20:0] code_point, pad 0s | [0] point_valid | text_done
//
// One byte per cycle unless stalled: input register, then one decode step
// against the partial code point state, then the output register.
// Without stalls a byte goes to the input register, its result to the output register.
// arst_n clears both valid flags and the decoder state.
// A stalled output holds; the input register still drains bytes that give
// no result, and takes a new byte whenever its content moves on.

module utf8_to_codepoint_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
	output logic        m_tuser,   // [0] point_valid
	output logic        m_tlast    // text_done
);

	logic                    valid_s1;
	logic [7:0]              byte_s1;
	logic                    last_s1;
	utf8cp_pkg::dec_state_t  state_q;
	utf8cp_pkg::dec_state_t  state_nxt;
	utf8cp_pkg::dec_result_t res;
	logic                    valid_s2;
	logic [20:0]             point_s2;
	logic                    pvalid_s2;
	logic                    done_s2;
	logic                    out_free;
	logic                    adv_s1;

	utf8cp_step u_step (
		.cur         (state_q),
		.data_byte   (byte_s1),
		.end_of_text (last_s1),
		.nxt         (state_nxt),
		.res         (res)
	);

	assign out_free = !valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && (out_free || !res.emit);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= adv_s1 && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && adv_s1 && res.emit) begin
			point_s2  <= res.code_point;
			pvalid_s2 <= res.point_valid;
			done_s2   <= res.text_done;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {3'd0, point_s2};
	assign m_tuser  = pvalid_s2;
	assign m_tlast  = done_s2;

	a_skip_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("result without a code point that does not end a text");

	a_skip_zero_point: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == 24'd0)
		else $error("nonzero code point on a skipped final byte");

	a_end_clears_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && last_s1 |=> state_q.pending == utf8cp_pkg::PEND_NONE
			&& state_q.partial == '0)
		else $error("decoder state not cleared after end of text");

	a_emit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && res.emit |-> out_free)
		else $error("result moved into an occupied output register");

endmodule

// File: rtl/core/utf8cp_step.sv
`timescale 1ns / 1ps

module utf8cp_step (
	input  utf8cp_pkg::dec_state_t  cur,
	input  logic [7:0]              data_byte,
	input  logic                    end_of_text,
	output utf8cp_pkg::dec_state_t  nxt,
	output utf8cp_pkg::dec_result_t res
);

	logic [utf8cp_pkg::POINT_W-1:0] merged;
	logic [utf8cp_pkg::PEND_W-1:0]  pend_dec;
	logic [utf8cp_pkg::POINT_W-1:0] lead_pt;
	logic [utf8cp_pkg::PEND_W-1:0]  lead_pend;

	always_comb begin
		unique case (cur.pending)
			utf8cp_pkg::PEND_THREE: merged = cur.partial | {3'd0, data_byte[5:0], 12'd0};
			utf8cp_pkg::PEND_TWO:   merged = cur.partial | {9'd0, data_byte[5:0], 6'd0};
			utf8cp_pkg::PEND_ONE:   merged = cur.partial | {15'd0, data_byte[5:0]};
			default:                merged = cur.partial;
		endcase
		pend_dec = cur.pending - utf8cp_pkg::PEND_ONE;
	end

	// lead byte decode
	always_comb begin
		priority if (data_byte[7:5] == 3'b110) begin
			lead_pt   = {10'd0, data_byte[4:0], 6'd0};
			lead_pend = utf8cp_pkg::PEND_ONE;
		end else if (data_byte[7:4] == 4'b1110) begin
			lead_pt   = {5'd0, data_byte[3:0], 12'd0};
			lead_pend = utf8cp_pkg::PEND_TWO;
		end else if (data_byte[7:3] == 5'b11110) begin
			lead_pt   = {data_byte[2:0], 18'd0};
			lead_pend = utf8cp_pkg::PEND_THREE;
		end else begin
			lead_pt   = '0;
			lead_pend = utf8cp_pkg::PEND_NONE;
		end
	end

	always_comb begin
		nxt             = cur;
		res.emit        = end_of_text;
		res.code_point  = '0;
		res.point_valid = 1'b0;
		res.text_done   = end_of_text;
		priority if (cur.pending != utf8cp_pkg::PEND_NONE) begin
			if (pend_dec == utf8cp_pkg::PEND_NONE || end_of_text) begin
				res.emit        = 1'b1;
				res.code_point  = merged;
				res.point_valid = 1'b1;
				nxt             = '0;
			end else begin
				nxt.partial = merged;
				nxt.pending = pend_dec;
			end
		end else if (!data_byte[7]) begin
			res.emit        = 1'b1;
			res.code_point  = {13'd0, data_byte};
			res.point_valid = 1'b1;
		end else if (lead_pend != utf8cp_pkg::PEND_NONE) begin
			if (end_of_text) begin
				res.code_point  = lead_pt;
				res.point_valid = 1'b1;
			end else begin
				nxt.partial = lead_pt;
				nxt.pending = lead_pend;
			end
		end else begin
			nxt = cur;
		end
		if (end_of_text) begin
			nxt = '0;
		end
	end

endmodule
